// ===== sv/bfi_pkg.sv =====
`default_nettype none
package bfi_pkg;

  // Default sizes of the bit store and the probe limit.
  localparam int unsigned WordsDef     = 1024;
  localparam int unsigned MaxProbesDef = 32;

  // Field and register widths.
  localparam int unsigned HashW      = 32;
  localparam int unsigned CntW       = 32;
  localparam int unsigned CfgProbesW = 6;
  localparam int unsigned CfgWordsW  = 11;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned WordBitsW  = 6;
  localparam int unsigned WordW      = 64;

  // Register indexes on the configuration channel.
  localparam logic [CfgIdxW-1:0] RegProbes = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegWords  = CfgIdxW'(1);

  // Register reset values.
  localparam logic [CfgProbesW-1:0] ProbesRst = CfgProbesW'(7);
  localparam logic [CfgWordsW-1:0]  WordsRst  = CfgWordsW'(1024);

  // Hash advance constants.
  localparam logic [HashW-1:0] HashMul  = HashW'(131);
  localparam int unsigned      RotRight = 17;
  localparam int unsigned      RotLeft  = 15;

  // The serial remainder works on the hash without its bit-in-word part.
  localparam int unsigned DivSteps = HashW - WordBitsW;
  localparam int unsigned StepW    = $clog2(DivSteps + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic div_step;
    logic mem_rd;
    logic mem_wr;
    logic miss;
    logic advance;
    logic finish;
    logic clr_wr;
  } bfi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic no_probes;
    logic div_done;
    logic is_test;
    logic bit_set;
    logic last_probe;
  } bfi_sts_t;

endpackage
`default_nettype wire

// ===== sv/bfi_if.sv =====
`default_nettype none
// Request channel: one key per transaction.
interface bfi_req_if import bfi_pkg::*;;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [HashW-1:0] key_hash;
  modport source (output valid, req_type, key_hash, input ready);
  modport sink   (input valid, req_type, key_hash, output ready);
endinterface

// Response channel: one result per request.
interface bfi_rsp_if import bfi_pkg::*;;
  logic            valid;
  logic            ready;
  logic            hit;
  logic [CntW-1:0] inserted_count;
  modport source (output valid, hit, inserted_count, input ready);
  modport sink   (input valid, hit, inserted_count, output ready);
endinterface

// Configuration write channel.
interface bfi_cfg_if import bfi_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/bfi_dpath.sv =====
`default_nettype none
module bfi_dpath import bfi_pkg::*; #(
  parameter int unsigned Words     = WordsDef,
  parameter int unsigned MaxProbes = MaxProbesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                req_type_i,
  input  wire logic [HashW-1:0]    key_hash_i,
  input  wire bfi_cmd_t            cmd_i,
  output bfi_sts_t                 sts_o,
  output logic                     hit_o,
  output logic [CntW-1:0]          inserted_count_o
);

  localparam int unsigned AddrW  = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PCntW  = $clog2(MaxProbes + 1);

  // Configuration registers.
  logic [CfgProbesW-1:0] probes_cfg_q;
  logic [CfgWordsW-1:0]  words_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probes_cfg_q <= ProbesRst;
      words_cfg_q  <= WordsRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegProbes) begin
        probes_cfg_q <= cfg_data_i[CfgProbesW-1:0];
      end
      if (cfg_index_i == RegWords) begin
        words_cfg_q <= cfg_data_i[CfgWordsW-1:0];
      end
    end
  end

  // Effective probe count and word count, clamped to the store's limits.
  logic [PCntW-1:0]     probes_eff;
  logic [CfgWordsW-1:0] words_eff;

  always_comb begin
    if ({{(32 - CfgProbesW){1'b0}}, probes_cfg_q} > 32'(MaxProbes)) begin
      probes_eff = PCntW'(MaxProbes);
    end else begin
      probes_eff = PCntW'(probes_cfg_q);
    end
    if (words_cfg_q == '0) begin
      words_eff = CfgWordsW'(1);
    end else if ({{(32 - CfgWordsW){1'b0}}, words_cfg_q} > 32'(Words)) begin
      words_eff = CfgWordsW'(Words);
    end else begin
      words_eff = words_cfg_q;
    end
  end

  // Per-key registers.
  logic                 is_test_q;
  logic                 hit_q;
  logic [HashW-1:0]     h_q;
  logic [HashW-1:0]     x_q;
  logic [PCntW-1:0]     probes_q;
  logic [PCntW-1:0]     probe_cnt_q;
  logic [CfgWordsW-1:0] words_q;
  logic [HashW-1:0]     h_next;

  assign h_next = (h_q * HashMul) + x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      is_test_q   <= req_type_i;
      hit_q       <= 1'b1;
      h_q         <= key_hash_i;
      x_q         <= (key_hash_i >> RotRight) | (key_hash_i << RotLeft);
      probes_q    <= probes_eff;
      probe_cnt_q <= '0;
      words_q     <= words_eff;
    end else begin
      if (cmd_i.miss) begin
        hit_q <= 1'b0;
      end
      if (cmd_i.advance) begin
        h_q         <= h_next;
        probe_cnt_q <= probe_cnt_q + PCntW'(1);
      end
    end
  end

  // Serial remainder: word index = (h / 64) mod words, one bit per cycle.
  logic [DivSteps-1:0]  dvd_q;
  logic [CfgWordsW-1:0] rem_q;
  logic [CfgWordsW-1:0] rem_d;
  logic [WordBitsW-1:0] bitpos_q;
  logic [StepW-1:0]     step_q;
  logic [CfgWordsW:0]   partial;

  assign partial = {rem_q, dvd_q[DivSteps-1]};

  always_comb begin
    if (partial >= {1'b0, words_q}) begin
      rem_d = CfgWordsW'(partial - {1'b0, words_q});
    end else begin
      rem_d = partial[CfgWordsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.start || cmd_i.advance) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dvd_q    <= key_hash_i[HashW-1:WordBitsW];
      bitpos_q <= key_hash_i[WordBitsW-1:0];
      rem_q    <= '0;
    end else if (cmd_i.advance) begin
      dvd_q    <= h_next[HashW-1:WordBitsW];
      bitpos_q <= h_next[WordBitsW-1:0];
      rem_q    <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  // Clearing sweep address after reset.
  logic [AddrW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  // Bit store with registered read; the remainder is below the word count.
  logic [WordW-1:0] mem [Words];
  logic [WordW-1:0] rdata_q;
  logic [WordW-1:0] mask;
  logic [AddrW-1:0] addr;

  assign addr = AddrW'(rem_q);
  assign mask = WordW'(1) << bitpos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[clr_addr_q] <= '0;
    end else if (cmd_i.mem_wr) begin
      mem[addr] <= rdata_q | mask;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[addr];
    end
  end

  // Insert counter counts at acceptance.
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start && !req_type_i) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Output payload register.
  logic            out_hit_q;
  logic [CntW-1:0] out_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_hit_q <= is_test_q & hit_q;
      out_cnt_q <= cnt_q;
    end
  end

  assign hit_o            = out_hit_q;
  assign inserted_count_o = out_cnt_q;

  // Status toward the controller.
  always_comb begin
    sts_o.clear_done = (clr_addr_q == AddrW'(Words - 1));
    sts_o.no_probes  = (probes_q == '0);
    sts_o.div_done   = (step_q == StepW'(DivSteps));
    sts_o.is_test    = is_test_q;
    sts_o.bit_set    = rdata_q[bitpos_q];
    sts_o.last_probe = ((probe_cnt_q + PCntW'(1)) == probes_q);
  end

`ifndef ASSERT_OFF
  // The remainder never exceeds the word count it divides by.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < words_q))
    else $error("remainder out of range");
`endif

endmodule
`default_nettype wire

// ===== sv/bfi_ctrl.sv =====
`default_nettype none
module bfi_ctrl import bfi_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     out_ready_i,
  input  wire bfi_sts_t sts_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output bfi_cmd_t      cmd_o
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StRd    = 3'd3;
  localparam logic [2:0] StChk   = 3'd4;
  localparam logic [2:0] StFin   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // Sequencing of one key: remainder, read, check or set, next probe.
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clear_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        if (sts_i.no_probes) begin
          state_d = StFin;
        end else if (sts_i.div_done) begin
          state_d = StRd;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StRd: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = StChk;
      end
      StChk: begin
        if (sts_i.is_test && !sts_i.bit_set) begin
          cmd_o.miss = 1'b1;
          state_d    = StFin;
        end else begin
          cmd_o.mem_wr = !sts_i.is_test;
          if (sts_i.last_probe) begin
            state_d = StFin;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = StDiv;
          end
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // A result is only loaded when the output register is free.
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // The store is read only once the remainder is complete.
  a_rd_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_rd |-> sts_i.div_done)
    else $error("store read before remainder done");

  // No request is taken during the clearing sweep.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !in_ready_o)
    else $error("request accepted while clearing");

  // The last probe of an insert ends the key.
  a_last_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StChk) && !sts_i.is_test && sts_i.last_probe) |=> (state_q == StFin))
    else $error("insert did not finish after last probe");
`endif

endmodule
`default_nettype wire

// ===== sv/bloom_filter_insert_query.sv =====
`default_nettype none
// Bloom filter bit store with insert and membership test. Each request carries a
// 32-bit key hash; probe positions are the hash modulo words_in_use * 64, and the
// hash advances between probes as h * 131 + rotr17(original hash). After reset the
// block clears the store, one word per cycle, over its Words words (1024 by default),
// and takes no request meanwhile; configuration writes are taken at any time.
// One request is processed at a time. Each probe runs the serial remainder unit,
// which takes one of the 26 upper hash bits per cycle, and then the registered read
// and the check or write-back of the store word; the reset probe count is seven.
// A test ends at its first clear bit. The result sits in an output register, so
// the next request is taken while it waits.
module bloom_filter_insert_query import bfi_pkg::*; #(
  parameter int unsigned Words     = WordsDef,
  parameter int unsigned MaxProbes = MaxProbesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfi_req_if.sink   req_i,
  bfi_rsp_if.source rsp_o,
  bfi_cfg_if.sink   cfg_i
);

  bfi_cmd_t cmd;
  bfi_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  bfi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  bfi_dpath #(
    .Words     (Words),
    .MaxProbes (MaxProbes)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .req_type_i       (req_i.req_type),
    .key_hash_i       (req_i.key_hash),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .hit_o            (rsp_o.hit),
    .inserted_count_o (rsp_o.inserted_count)
  );

endmodule
`default_nettype wire

// ===== tb/bloom_filter_checker.sv =====
`timescale 1ns / 100ps
// Watches the request, response and configuration channels of the Bloom
// filter. It keeps its own copy of the bit store, the insert counter and the
// two registers, works out the answer of every accepted request transaction
// and compares each response transaction with the oldest answer still due.
module bloom_filter_checker import bfi_pkg::*; #(
  parameter int unsigned Words     = WordsDef,
  parameter int unsigned MaxProbes = MaxProbesDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bfi_req_if         req_i,
  bfi_rsp_if         rsp_i,
  bfi_cfg_if         cfg_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic            hit;
    logic [CntW-1:0] inserted_count;
  } filter_answer_t;

  // Shadow state of the filter.
  logic [WordW-1:0]      filter_bits [Words];
  logic [CntW-1:0]       key_total;
  logic [CfgProbesW-1:0] probes_cfg;
  logic [CfgWordsW-1:0]  words_cfg;

  filter_answer_t answers_due [$];
  filter_answer_t want;
  int unsigned    mismatch_total = 0;

  // Probes the shadow store for one key, sets bits on an insert, and queues
  // the answer that the block has to give for it.
  task automatic apply_key(input logic is_test, input logic [HashW-1:0] key);
    logic [HashW-1:0] h;
    logic [HashW-1:0] mix;
    logic [HashW-1:0] pos;
    logic [HashW-1:0] span;
    int unsigned      n_probes;
    int unsigned      n_words;
    int unsigned      word_idx;
    logic             hit;
    logic             stop;
    filter_answer_t   ans;
    h    = key;
    mix  = {key[RotRight-1:0], key[HashW-1:RotRight]};
    // Out-of-range register values saturate; zero words counts as one.
    n_probes = (probes_cfg > MaxProbes) ? MaxProbes : probes_cfg;
    if (words_cfg == 0) begin
      n_words = 1;
    end else if (words_cfg > Words) begin
      n_words = Words;
    end else begin
      n_words = words_cfg;
    end
    span = HashW'(n_words * WordW);
    hit  = 1'b1;
    stop = 1'b0;
    if (!is_test) begin
      key_total = key_total + 1'b1;
    end
    for (int i = 0; i < n_probes; i++) begin
      if (!stop) begin
        pos      = h % span;
        word_idx = (pos >> WordBitsW) % Words;
        if (is_test) begin
          // A test stops at its first clear bit.
          if (!filter_bits[word_idx][pos[WordBitsW-1:0]]) begin
            hit  = 1'b0;
            stop = 1'b1;
          end
        end else begin
          filter_bits[word_idx][pos[WordBitsW-1:0]] = 1'b1;
        end
        h = h * HashMul + mix;
      end
    end
    ans.hit            = is_test ? hit : 1'b0;
    ans.inserted_count = key_total;
    answers_due.push_back(ans);
  endtask

  // Channel monitor. Responses are handled first, since a response accepted
  // at the same edge as a request always belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (filter_bits[w]) begin
        filter_bits[w] = '0;
      end
      key_total  = '0;
      probes_cfg = ProbesRst;
      words_cfg  = WordsRst;
      answers_due.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (answers_due.size() == 0) begin
          if (mismatch_total < 10) begin
            $display("unexpected result transaction: hit %0b count %0d",
                     rsp_i.hit, rsp_i.inserted_count);
          end
          mismatch_total++;
        end else begin
          want = answers_due.pop_front();
          if (rsp_i.hit !== want.hit || rsp_i.inserted_count !== want.inserted_count) begin
            if (mismatch_total < 10) begin
              $display("result mismatch: expected hit %0b count %0d, got hit %0b count %0d",
                       want.hit, want.inserted_count, rsp_i.hit, rsp_i.inserted_count);
            end
            mismatch_total++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == RegProbes) begin
          probes_cfg = cfg_i.data[CfgProbesW-1:0];
        end else if (cfg_i.index == RegWords) begin
          words_cfg = cfg_i.data[CfgWordsW-1:0];
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_key(req_i.req_type, req_i.key_hash);
      end
    end
    pending_o    <= answers_due.size();
    mismatches_o <= mismatch_total;
  end

endmodule

// ===== tb/bloom_filter_insert_query_test.sv =====
`timescale 1ns / 100ps
// Drives keys and register settings into the Bloom filter and gives the
// verdict; the checker beside the block predicts and compares.
module bloom_filter_insert_query_test;
  import bfi_pkg::*;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqTest   = 1'b1;

  typedef enum logic [1:0] {RdyAlways, RdyCoin, RdySparse, RdyBlocks} ready_mode_e;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        rsp_ready = 1'b0;
  int unsigned mismatches;
  int unsigned pending;

  ready_mode_e ready_mode = RdyAlways;
  int unsigned mode_left  = 0;

  // Recently inserted keys, reused so that tests actually hit.
  logic [HashW-1:0] inserted_keys [$];

  // Settings per phase: probe count, word count and number of keys.
  int unsigned phase_probes [11] = '{7, 1, 3, 32, 0, 12, 2, 5, 40, 20, 4};
  int unsigned phase_words  [11] = '{1024, 1, 2, 1024, 5, 16, 1023, 64, 7, 0, 1500};
  int unsigned phase_items  [11] = '{150, 100, 100, 30, 50, 120, 100, 120, 30, 60, 90};

  bfi_req_if req_ch ();
  bfi_rsp_if rsp_ch ();
  bfi_cfg_if cfg_ch ();

  assign rsp_ch.ready = rsp_ready;

  bloom_filter_insert_query dut (
    .clk_i,
    .rst_ni,
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  bloom_filter_checker filter_monitor (
    .clk_i,
    .rst_ni,
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .cfg_i        (cfg_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // Response stall pattern: the ready mode is redrawn at random.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 600);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RdyAlways: begin
        rsp_ready <= 1'b1;
      end
      RdyCoin: begin
        rsp_ready <= 1'($urandom_range(0, 1));
      end
      RdySparse: begin
        rsp_ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        rsp_ready <= mode_left[5];
      end
    endcase
  end

  // One request transaction; valid stays high for a following key.
  task automatic send_key(input logic kind, input logic [HashW-1:0] key);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.key_hash <= key;
    do @(posedge clk_i); while (!req_ch.ready);
    if (kind == ReqInsert) begin
      inserted_keys.push_back(key);
      if (inserted_keys.size() > 64) begin
        void'(inserted_keys.pop_front());
      end
    end
  endtask

  // One configuration transaction; the caller lowers valid afterwards.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Waits until every expected result has come back.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Writes both registers with random upper bits, which the block drops, and
  // one index that has no register behind it.
  task automatic set_filter(input int unsigned probes, input int unsigned words);
    settle();
    write_reg(RegProbes, (CfgDataW'($urandom()) << CfgProbesW) | CfgDataW'(probes));
    write_reg(RegWords, (CfgDataW'($urandom()) << CfgWordsW) | CfgDataW'(words));
    write_reg(CfgIdxW'($urandom_range(2, 255)), $urandom());
    cfg_ch.valid <= 1'b0;
  endtask

  // Random keys in bursts: mostly inserts and tests of inserted keys, plus
  // fresh keys, near misses and the extreme hashes.
  task automatic random_keys(input int unsigned n);
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      gap;
    logic [HashW-1:0] key;
    logic             kind;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < n; b++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            kind = ReqInsert;
            key  = $urandom();
          end
          4, 5, 6: begin
            kind = ReqTest;
            key  = (inserted_keys.size() == 0) ? $urandom() :
                   inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
          end
          7: begin
            kind = ReqTest;
            key  = (inserted_keys.size() == 0) ? $urandom() :
                   inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            key  = key ^ (HashW'(1) << $urandom_range(0, HashW - 1));
          end
          8: begin
            kind = ReqTest;
            key  = $urandom();
          end
          default: begin
            kind = 1'($urandom_range(0, 1));
            key  = $urandom_range(0, 1) ? '1 : '0;
          end
        endcase
        send_key(kind, key);
        sent++;
      end
      case ($urandom_range(0, 5))
        0, 1: gap = 0;
        2, 3: gap = $urandom_range(1, 8);
        4: gap = $urandom_range(9, 60);
        default: gap = $urandom_range(61, 400);
      endcase
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    req_ch.valid    = 1'b0;
    req_ch.req_type = ReqInsert;
    req_ch.key_hash = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: empty store, then the extreme hashes.
    send_key(ReqTest, 32'h0000_0000);
    send_key(ReqInsert, 32'h0000_0000);
    send_key(ReqTest, 32'h0000_0000);
    send_key(ReqInsert, 32'hFFFF_FFFF);
    send_key(ReqTest, 32'hFFFF_FFFF);
    send_key(ReqTest, 32'h9E37_79B9);
    send_key(ReqInsert, 32'h8000_0000);
    send_key(ReqTest, 32'h8000_0001);

    // Zero probes: an insert only counts and a test always hits.
    set_filter(0, 1024);
    send_key(ReqInsert, 32'hA5A5_A5A5);
    send_key(ReqTest, 32'h1234_5678);

    // Probe count above the limit, and zero words.
    set_filter(63, 0);
    send_key(ReqInsert, 32'h5A5A_5A5A);
    send_key(ReqTest, 32'h0F0F_0F0F);
    send_key(ReqTest, 32'h5A5A_5A5A);

    // Largest legal probe count, and a word count above the store size.
    set_filter(32, 2047);
    send_key(ReqInsert, 32'h7FFF_FFFF);
    send_key(ReqTest, 32'h7FFF_FFFF);
    send_key(ReqTest, 32'hFFFF_FFFE);

    // Smallest filter.
    set_filter(1, 1);
    send_key(ReqInsert, 32'h0000_0001);
    send_key(ReqTest, 32'h0000_003F);
    send_key(ReqTest, 32'h0000_0040);

    set_filter(40, 1025);
    send_key(ReqTest, 32'hDEAD_BEEF);

    for (int p = 0; p < 11; p++) begin
      set_filter(phase_probes[p], phase_words[p]);
      random_keys(phase_items[p]);
    end

    settle();
    repeat (1000) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bfi_pkg.sv
sv/bfi_if.sv
sv/bfi_dpath.sv
sv/bfi_ctrl.sv
sv/bloom_filter_insert_query.sv
tb/bloom_filter_checker.sv
tb/bloom_filter_insert_query_test.sv
